// ===== rtl/ubrb_pkg.sv =====
`default_nettype none

package ubrb_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int FUNC_W   = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE  = 3'd0,
        FUNC_HOST_RD  = 3'd1,
        FUNC_HOST_WR  = 3'd2,
        FUNC_TX_READY = 3'd3,
        FUNC_RX_FLUSH = 3'd4
    } t_func;

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ubrb_ram.sv =====
`default_nettype none

module ubrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/uart_byte_ring_buffers_top.sv =====
// channel   | handshake           | signals
// ----------+---------------------+--------------------------------------------
// request   | start && !busy      | i_func, i_data_byte
// result    | o_done (one cycle)  | o_read_byte, o_line_valid, o_line_byte,
//           |                     | o_rx_count, o_tx_empty, o_write_refused
//
// busy is always low: a request is taken every cycle and its result shows
// in the next cycle, from the registered read port of the two byte rams.
// pointers and flags update at the accept edge, so back-to-back requests
// see each other's effects. synchronous active-low reset empties both rings
// and marks the transmitter idle; no ram clearing is done. the receiver
// cannot stall, so every result is on the ports for exactly one cycle.
`default_nettype none

module uart_byte_ring_buffers_top
    import ubrb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [BYTE_W-1:0]  i_data_byte,
    output logic                    o_done,
    output logic [BYTE_W-1:0]       o_read_byte,
    output logic                    o_line_valid,
    output logic [BYTE_W-1:0]       o_line_byte,
    output logic [COUNT_W-1:0]      o_rx_count,
    output logic                    o_tx_empty,
    output logic                    o_write_refused
);

    logic [RX_AW-1:0]   r_rx_head, r_rx_tail, n_rx_head, n_rx_tail;
    logic [TX_AW-1:0]   r_tx_head, r_tx_tail, n_tx_head, n_tx_tail;
    logic               r_tx_idle, n_tx_idle;
    logic               r_done;
    logic               r_rd_sel, n_rd_sel;
    logic               r_line_valid, n_line_valid;
    logic               r_line_from_ram, n_line_from_ram;
    logic               r_refused, n_refused;
    logic [BYTE_W-1:0]  r_data;
    logic [COUNT_W-1:0] r_rx_count, n_rx_count;
    logic               r_tx_empty;
    logic               rx_we, tx_we;
    logic [BYTE_W-1:0]  rx_rdata, tx_rdata;
    logic               accept;
    logic [RX_AW:0]     rx_diff;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        n_rx_head       = r_rx_head;
        n_rx_tail       = r_rx_tail;
        n_tx_head       = r_tx_head;
        n_tx_tail       = r_tx_tail;
        n_tx_idle       = r_tx_idle;
        n_rd_sel        = 1'b0;
        n_line_valid    = 1'b0;
        n_line_from_ram = 1'b0;
        n_refused       = 1'b0;
        rx_we           = 1'b0;
        tx_we           = 1'b0;
        if (accept) begin
            unique case (i_func)
                FUNC_RX_BYTE: begin
                    rx_we     = 1'b1;
                    n_rx_head = rx_next(r_rx_head);
                    // overflow drops the oldest byte
                    if (n_rx_head == r_rx_tail) begin
                        n_rx_tail = rx_next(r_rx_tail);
                    end
                end
                FUNC_HOST_RD: begin
                    if (r_rx_head != r_rx_tail) begin
                        n_rd_sel  = 1'b1;
                        n_rx_tail = rx_next(r_rx_tail);
                    end
                end
                FUNC_HOST_WR: begin
                    priority if (r_tx_head == r_tx_tail && r_tx_idle) begin
                        n_line_valid = 1'b1;
                        n_tx_idle    = 1'b0;
                    end else if (tx_next(r_tx_head) == r_tx_tail) begin
                        n_refused = 1'b1;
                    end else begin
                        tx_we     = 1'b1;
                        n_tx_head = tx_next(r_tx_head);
                    end
                end
                FUNC_TX_READY: begin
                    if (r_tx_head != r_tx_tail) begin
                        n_line_valid    = 1'b1;
                        n_line_from_ram = 1'b1;
                        n_tx_tail       = tx_next(r_tx_tail);
                        n_tx_idle       = 1'b0;
                    end else begin
                        n_tx_idle = 1'b1;
                    end
                end
                FUNC_RX_FLUSH: begin
                    n_rx_head = '0;
                    n_rx_tail = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (n_rx_head >= n_rx_tail) begin
            rx_diff = {1'b0, n_rx_head} - {1'b0, n_rx_tail};
        end else begin
            rx_diff = {1'b0, n_rx_head} + (RX_AW + 1)'(RX_DEPTH) - {1'b0, n_rx_tail};
        end
        n_rx_count = COUNT_W'(rx_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head    <= '0;
            r_rx_tail    <= '0;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_tx_idle    <= 1'b1;
            r_done       <= 1'b0;
            r_rd_sel     <= 1'b0;
            r_line_valid <= 1'b0;
            r_refused    <= 1'b0;
        end else begin
            r_rx_head    <= n_rx_head;
            r_rx_tail    <= n_rx_tail;
            r_tx_head    <= n_tx_head;
            r_tx_tail    <= n_tx_tail;
            r_tx_idle    <= n_tx_idle;
            r_done       <= accept;
            r_rd_sel     <= n_rd_sel;
            r_line_valid <= n_line_valid;
            r_refused    <= n_refused;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data          <= i_data_byte;
        r_line_from_ram <= n_line_from_ram;
        r_rx_count      <= n_rx_count;
        r_tx_empty      <= (n_tx_head == n_tx_tail);
    end

    ubrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (i_data_byte),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    ubrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (i_data_byte),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    assign o_done          = r_done;
    assign o_read_byte     = r_rd_sel ? rx_rdata : '0;
    assign o_line_valid    = r_line_valid;
    assign o_line_byte     = r_line_valid ? (r_line_from_ram ? tx_rdata : r_data) : '0;
    assign o_rx_count      = r_rx_count;
    assign o_tx_empty      = r_tx_empty;
    assign o_write_refused = r_refused;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("result strobe missing after accepted request");

    a_flags_need_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (!o_line_valid && !o_write_refused && !r_rd_sel))
        else $error("result flag set without result strobe");

    a_refuse_excl_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_line_valid && o_write_refused))
        else $error("write refused and byte sent at once");

    a_rx_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_RX_BYTE) |=> (o_rx_count != '0))
        else $error("receive ring empty after storing a byte");

    a_refused_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_HOST_WR && tx_next(r_tx_head) != r_tx_tail)
        |=> !o_write_refused)
        else $error("write refused with room in transmit ring");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_uart_byte_ring_buffers_top.sv =====
`default_nettype none

module tb_uart_byte_ring_buffers_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ubrb_pkg::*;

    // func codes the block decodes as no-ops
    localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 4;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_byte;
        logic               line_valid;
        logic [BYTE_W-1:0]  line_byte;
        logic [COUNT_W-1:0] rx_count;
        logic               tx_empty;
        logic               write_refused;
    } ring_status_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data;
        int                idle_pct;
        bit                drain_first;
    } port_op_t;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [FUNC_W-1:0]     i_func      = '0;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  busy;
    logic                  o_done;
    logic [BYTE_W-1:0]     o_read_byte;
    logic                  o_line_valid;
    logic [BYTE_W-1:0]     o_line_byte;
    logic [COUNT_W-1:0]    o_rx_count;
    logic                  o_tx_empty;
    logic                  o_write_refused;

    uart_byte_ring_buffers_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .o_done          (o_done),
        .o_read_byte     (o_read_byte),
        .o_line_valid    (o_line_valid),
        .o_line_byte     (o_line_byte),
        .o_rx_count      (o_rx_count),
        .o_tx_empty      (o_tx_empty),
        .o_write_refused (o_write_refused)
    );

    // predicted ring state
    logic [BYTE_W-1:0] rx_bytes [RX_DEPTH];
    logic [BYTE_W-1:0] tx_bytes [TX_DEPTH];
    logic [RX_AW-1:0]  rx_wr = '0;
    logic [RX_AW-1:0]  rx_rd = '0;
    logic [TX_AW-1:0]  tx_wr = '0;
    logic [TX_AW-1:0]  tx_rd = '0;
    logic              tx_idle = 1'b1;

    port_op_t     pending_ops[$];
    ring_status_t expected_status[$];

    int  phase_idle_pct = 0;
    bit  drain_next     = 1'b0;
    int  ops_total      = 0;
    int  ops_accepted   = 0;
    int  n_errors       = 0;
    int  quiet_cycles   = 0;
    bit  req_taken      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        return RX_AW'((int'(p) + 1) % RX_DEPTH);
    endfunction

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        return TX_AW'((int'(p) + 1) % TX_DEPTH);
    endfunction

    function automatic ring_status_t predict_ring_status(input logic [FUNC_W-1:0] func,
                                                         input logic [BYTE_W-1:0] data);
        ring_status_t s;
        s = '0;
        case (func)
            FUNC_RX_BYTE: begin
                rx_bytes[rx_wr] = data;
                rx_wr = rx_inc(rx_wr);
                // overflow drops the oldest byte
                if (rx_wr == rx_rd) rx_rd = rx_inc(rx_rd);
            end
            FUNC_HOST_RD: begin
                if (rx_wr != rx_rd) begin
                    s.read_byte = rx_bytes[rx_rd];
                    rx_rd = rx_inc(rx_rd);
                end
            end
            FUNC_HOST_WR: begin
                if (tx_wr == tx_rd && tx_idle) begin
                    s.line_valid = 1'b1;
                    s.line_byte  = data;
                    tx_idle      = 1'b0;
                end else if (tx_inc(tx_wr) == tx_rd) begin
                    s.write_refused = 1'b1;
                end else begin
                    tx_bytes[tx_wr] = data;
                    tx_wr = tx_inc(tx_wr);
                end
            end
            FUNC_TX_READY: begin
                if (tx_wr != tx_rd) begin
                    s.line_valid = 1'b1;
                    s.line_byte  = tx_bytes[tx_rd];
                    tx_rd        = tx_inc(tx_rd);
                    tx_idle      = 1'b0;
                end else begin
                    tx_idle = 1'b1;
                end
            end
            FUNC_RX_FLUSH: begin
                rx_wr = '0;
                rx_rd = '0;
                rx_bytes[0] = '0;
            end
            default: begin
            end
        endcase
        s.rx_count = COUNT_W'((int'(rx_wr) + RX_DEPTH - int'(rx_rd)) % RX_DEPTH);
        s.tx_empty = (tx_wr == tx_rd);
        return s;
    endfunction

    function automatic void flag_error(input string what, input ring_status_t want,
                                       input ring_status_t got);
        n_errors++;
        if (n_errors <= MAX_REPORTED)
            $display("%0t %s: exp rd=%02h lv=%0b lb=%02h cnt=%0d te=%0b wr=%0b",
                     $realtime, what, want.read_byte, want.line_valid, want.line_byte,
                     want.rx_count, want.tx_empty, want.write_refused,
                     "\n    got rd=%02h lv=%0b lb=%02h cnt=%0d te=%0b wr=%0b",
                     got.read_byte, got.line_valid, got.line_byte,
                     got.rx_count, got.tx_empty, got.write_refused);
    endfunction

    // driver: next request goes out at the falling edge
    always @(negedge i_clk) begin
        port_op_t op;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (pending_ops.size() != 0
                && !(pending_ops[0].drain_first && expected_status.size() != 0)
                && $urandom_range(0, 99) >= pending_ops[0].idle_pct) begin
                op = pending_ops.pop_front();
                start       <= 1'b1;
                i_func      <= op.func;
                i_data_byte <= op.data;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on accept, check on done
    always @(posedge i_clk) begin
        ring_status_t got;
        ring_status_t want;
        req_taken = i_rst_n && start && !busy;
        if (req_taken) begin
            expected_status.push_back(predict_ring_status(i_func, i_data_byte));
            ops_accepted++;
        end
        if (i_rst_n && o_done) begin
            got.read_byte     = o_read_byte;
            got.line_valid    = o_line_valid;
            got.line_byte     = o_line_byte;
            got.rx_count      = o_rx_count;
            got.tx_empty      = o_tx_empty;
            got.write_refused = o_write_refused;
            if (expected_status.size() == 0) begin
                flag_error("unexpected result", '0, got);
            end else begin
                want = expected_status.pop_front();
                if (got.read_byte !== want.read_byte || got.line_valid !== want.line_valid
                    || got.line_byte !== want.line_byte || got.rx_count !== want.rx_count
                    || got.tx_empty !== want.tx_empty
                    || got.write_refused !== want.write_refused)
                    flag_error("mismatch", want, got);
            end
        end
        quiet_cycles = (req_taken || (i_rst_n && o_done === 1'b1)) ? 0 : quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic push_op(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data);
        port_op_t op;
        op.func        = func;
        op.data        = data;
        op.idle_pct    = phase_idle_pct;
        op.drain_first = drain_next;
        drain_next     = 1'b0;
        pending_ops.push_back(op);
        ops_total++;
    endtask

    task automatic push_run(input logic [FUNC_W-1:0] func, input int len);
        for (int k = 0; k < len; k++) push_op(func, BYTE_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [FUNC_W-1:0] pick_mixed_func();
        case ($urandom_range(0, 9))
            0, 1, 2: return FUNC_RX_BYTE;
            3, 4:    return FUNC_HOST_RD;
            5, 6:    return FUNC_HOST_WR;
            7, 8:    return FUNC_TX_READY;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return FUNC_RX_FLUSH;
                    1:       return FUNC_RSVD_5;
                    2:       return FUNC_RSVD_6;
                    default: return FUNC_RSVD_7;
                endcase
            end
        endcase
    endfunction

    // bursts of one func reach overflow and a full transmit ring; mixed runs add noise
    task automatic push_random_until(input int stop_at);
        int len;
        while (ops_total < stop_at) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 16);
            case ($urandom_range(0, 5))
                0: push_run(FUNC_RX_BYTE, len);
                1: push_run(FUNC_HOST_RD, len);
                2: push_run(FUNC_HOST_WR, len);
                3: push_run(FUNC_TX_READY, len);
                default: begin
                    for (int k = 0; k < len; k++)
                        push_op(pick_mixed_func(), BYTE_W'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        // directed: empty read, idle ready, unused codes, flush, direct and queued writes
        push_op(FUNC_HOST_RD,  8'h00);
        push_op(FUNC_TX_READY, 8'h00);
        push_op(FUNC_RSVD_5,   8'hA5);
        push_op(FUNC_RSVD_6,   8'h00);
        push_op(FUNC_RSVD_7,   8'hFF);
        push_op(FUNC_RX_BYTE,  8'h00);
        push_op(FUNC_RX_BYTE,  8'hFF);
        push_op(FUNC_RX_BYTE,  8'h5A);
        push_op(FUNC_HOST_RD,  8'h00);
        push_op(FUNC_HOST_RD,  8'hFF);
        push_op(FUNC_RX_FLUSH, 8'hFF);
        push_op(FUNC_HOST_RD,  8'h00);
        push_op(FUNC_HOST_WR,  8'hFF);
        push_op(FUNC_HOST_WR,  8'h00);
        push_op(FUNC_HOST_WR,  8'h81);
        push_op(FUNC_TX_READY, 8'h00);
        push_op(FUNC_TX_READY, 8'h00);
        push_op(FUNC_TX_READY, 8'h00);
        push_op(FUNC_HOST_WR,  8'h3C);
        push_op(FUNC_TX_READY, 8'h00);
        push_op(FUNC_RX_BYTE,  8'h80);
        push_op(FUNC_RX_FLUSH, 8'h00);

        // fill both rings past their limits, then drain them dry
        push_run(FUNC_RX_BYTE, 68);
        push_run(FUNC_HOST_WR, 67);
        push_run(FUNC_TX_READY, 66);
        push_run(FUNC_HOST_RD, 66);

        drain_next = 1'b1;
        phase_idle_pct = 84;
        push_random_until(420);
        drain_next = 1'b1;
        phase_idle_pct = 0;
        push_random_until(530);
        drain_next = 1'b1;
        phase_idle_pct = 29;
        push_random_until(640);

        while (ops_accepted < ops_total || expected_status.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        n_errors += expected_status.size();

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/ubrb_pkg.sv
rtl/ubrb_ram.sv
rtl/uart_byte_ring_buffers_top.sv
tb/tb_uart_byte_ring_buffers_top.sv
